// ----- src/nif_pkg.sv -----
// ----------------------------------------------------------------------------
// nif_pkg
// Shared types, register codes and helpers of the packet network interface.
// ----------------------------------------------------------------------------
package nif_pkg;

   localparam int TX_WORDS = 256;
   localparam int RX_WORDS = 512;
   localparam int TX_AW    = $clog2(TX_WORDS);
   localparam int TX_CW    = $clog2(TX_WORDS + 1);
   localparam int RX_AW    = $clog2(RX_WORDS);
   localparam int RX_CW    = $clog2(RX_WORDS + 1);

   // operation codes
   localparam logic [2:0] OP_BUS_WRITE = 3'd0;
   localparam logic [2:0] OP_BUS_READ  = 3'd1;
   localparam logic [2:0] OP_RX_WORD   = 3'd2;
   localparam logic [2:0] OP_TICK      = 3'd3;
   localparam logic [2:0] OP_LINK_PULL = 3'd4;

   // register offsets
   localparam logic [2:0] REG_CSR      = 3'd0;
   localparam logic [2:0] REG_BUF_HOST = 3'd1;
   localparam logic [2:0] REG_RD_BUF   = 3'd2;
   localparam logic [2:0] REG_BIT_CNT  = 3'd3;
   localparam logic [2:0] REG_TX_START = 3'd5;

   // CSR bit positions
   localparam int B_SPY = 2;
   localparam int B_RCL = 3;
   localparam int B_REN = 4;
   localparam int B_TEN = 5;
   localparam int B_TDN = 7;
   localparam int B_TCL = 8;
   localparam int B_LST = 9;
   localparam int B_RST = 13;
   localparam int B_ERR = 14;
   localparam int B_RDN = 15;

   // index of the source word in a transmit packet
   localparam logic [TX_CW-1:0] SRC_POS = TX_CW'(4);
   // index of the destination word in a received packet
   localparam logic [RX_CW-1:0] DEST_POS = RX_CW'(2);

   typedef struct packed {
      logic [2:0]  op;
      logic [2:0]  reg_offset;
      logic [15:0] write_data;
      logic [15:0] rx_word;
      logic        rx_last;
   } item_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        irq;
      logic        tx_valid;
      logic [15:0] tx_word;
      logic        tx_last;
   } result_type;

   // ones'-complement add with end-around carry
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'b0, s[16]};
   endfunction

endpackage

// ----- src/nif_ram.sv -----
// ----------------------------------------------------------------------------
// nif_ram
// Single-port-write, single-port-read RAM with registered, write-first read.
// ----------------------------------------------------------------------------
module nif_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // forward data written at the same edge to the same address
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/nif_core.sv -----
// ----------------------------------------------------------------------------
// nif_core
// Device state, transmit and receive stores and the per-transfer update.
// ----------------------------------------------------------------------------
module nif_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  nif_pkg::item_type   item,
   input  logic [15:0]         node_address,
   output nif_pkg::result_type result
);

   localparam int TX_AW = nif_pkg::TX_AW;
   localparam int TX_CW = nif_pkg::TX_CW;
   localparam int RX_AW = nif_pkg::RX_AW;
   localparam int RX_CW = nif_pkg::RX_CW;

   logic [2:0]       enable_ff, enable_in;
   logic             tx_done_ff, tx_done_in;
   logic             crc_error_ff, crc_error_in;
   logic             rx_done_ff, rx_done_in;
   logic [3:0]       lost_ff, lost_in;
   logic             irq_ff, irq_in;
   logic [TX_CW-1:0] tx_fill_ff, tx_fill_in;
   logic [15:0]      tx_sum_ff, tx_sum_in;
   logic             busy_ff, busy_in;
   logic [TX_CW-1:0] send_pos_ff, send_pos_in;
   logic [TX_CW-1:0] send_len_ff, send_len_in;
   logic [RX_CW-1:0] rx_avail_ff, rx_avail_in;
   logic [RX_CW-1:0] rx_pos_ff, rx_pos_in;
   logic [RX_CW-1:0] rx_fill_ff, rx_fill_in;
   logic [15:0]      rx_sum_ff, rx_sum_in;
   logic [15:0]      rx_dest_ff, rx_dest_in;
   logic             rx_en_ff, rx_en_in;
   // copy of transmit word 4, and the two words appended at start
   logic [15:0]      src_word_ff, src_word_in;
   logic [15:0]      app_src_ff, app_src_in;
   logic [15:0]      app_chk_ff, app_chk_in;

   logic             tx_we;
   logic [15:0]      tx_rdata;
   logic             rx_we;
   logic [15:0]      rx_rdata;
   logic             rx_free;
   logic [15:0]      chk;
   logic [TX_CW-1:0] pos_next;
   nif_pkg::result_type res;

   always_comb begin
      enable_in   = enable_ff;
      tx_done_in  = tx_done_ff;
      crc_error_in = crc_error_ff;
      rx_done_in  = rx_done_ff;
      lost_in     = lost_ff;
      irq_in      = irq_ff;
      tx_fill_in  = tx_fill_ff;
      tx_sum_in   = tx_sum_ff;
      busy_in     = busy_ff;
      send_pos_in = send_pos_ff;
      send_len_in = send_len_ff;
      rx_avail_in = rx_avail_ff;
      rx_pos_in   = rx_pos_ff;
      rx_fill_in  = rx_fill_ff;
      rx_sum_in   = rx_sum_ff;
      rx_dest_in  = rx_dest_ff;
      rx_en_in    = rx_en_ff;
      src_word_in = src_word_ff;
      app_src_in  = app_src_ff;
      app_chk_in  = app_chk_ff;
      tx_we       = 1'b0;
      rx_we       = 1'b0;
      rx_free     = rx_en_ff && !rx_done_ff;
      chk         = ~nif_pkg::oc_add(tx_sum_ff, src_word_ff);
      pos_next    = send_pos_ff + TX_CW'(1);
      res         = '0;

      case (item.op)
         nif_pkg::OP_BUS_WRITE: begin
            if (item.reg_offset == nif_pkg::REG_CSR) begin
               if (item.write_data[nif_pkg::B_RST]) begin
                  tx_done_in   = 1'b1;
                  crc_error_in = 1'b0;
                  rx_done_in   = 1'b0;
                  lost_in      = '0;
                  irq_in       = 1'b0;
                  tx_fill_in   = '0;
                  tx_sum_in    = '0;
                  busy_in      = 1'b0;
                  send_pos_in  = '0;
                  send_len_in  = '0;
                  rx_avail_in  = '0;
                  rx_pos_in    = '0;
                  rx_fill_in   = '0;
                  rx_sum_in    = '0;
                  rx_dest_in   = '0;
                  rx_en_in     = 1'b1;
               end
               enable_in = {item.write_data[nif_pkg::B_TEN], item.write_data[nif_pkg::B_REN],
                            item.write_data[nif_pkg::B_SPY]};
               if (item.write_data[nif_pkg::B_RCL]) begin
                  rx_done_in  = 1'b0;
                  rx_avail_in = '0;
                  rx_pos_in   = '0;
                  rx_en_in    = 1'b1;
                  irq_in      = 1'b0;
               end
               if (item.write_data[nif_pkg::B_TCL]) begin
                  tx_fill_in = '0;
                  tx_sum_in  = '0;
                  tx_done_in = 1'b1;
                  if (enable_in[2]) begin
                     irq_in = 1'b1;
                  end
               end
            end else if (item.reg_offset == nif_pkg::REG_BUF_HOST && !busy_ff) begin
               tx_done_in = 1'b0;
               if (tx_fill_ff < TX_CW'(nif_pkg::TX_WORDS)) begin
                  tx_we      = 1'b1;
                  tx_fill_in = tx_fill_ff + TX_CW'(1);
                  tx_sum_in  = nif_pkg::oc_add(tx_sum_ff, item.write_data);
                  if (tx_fill_ff == nif_pkg::SRC_POS) begin
                     src_word_in = item.write_data;
                  end
               end
            end
         end
         nif_pkg::OP_BUS_READ: begin
            case (item.reg_offset)
               nif_pkg::REG_CSR: begin
                  res.read_data[nif_pkg::B_SPY] = enable_ff[0];
                  res.read_data[nif_pkg::B_REN] = enable_ff[1];
                  res.read_data[nif_pkg::B_TEN] = enable_ff[2];
                  res.read_data[nif_pkg::B_TDN] = tx_done_ff;
                  res.read_data[nif_pkg::B_LST +: 4] = lost_ff;
                  res.read_data[nif_pkg::B_ERR] = crc_error_ff;
                  res.read_data[nif_pkg::B_RDN] = rx_done_ff;
               end
               nif_pkg::REG_BUF_HOST: res.read_data = node_address;
               nif_pkg::REG_RD_BUF: begin
                  if (rx_avail_ff != '0 && rx_pos_ff < RX_CW'(nif_pkg::RX_WORDS)) begin
                     rx_done_in     = 1'b0;
                     irq_in         = 1'b0;
                     res.read_data  = rx_rdata;
                     rx_avail_in    = rx_avail_ff - RX_CW'(1);
                     rx_pos_in      = rx_pos_ff + RX_CW'(1);
                  end
               end
               nif_pkg::REG_BIT_CNT: begin
                  res.read_data = {4'b0, {rx_avail_ff[7:0], 4'b0} - 12'd1};
               end
               nif_pkg::REG_TX_START: begin
                  if (!busy_ff) begin
                     if (tx_fill_ff > TX_CW'(nif_pkg::TX_WORDS - 2)) begin
                        crc_error_in = 1'b1;
                     end else begin
                        app_src_in = src_word_ff;
                        app_chk_in = chk;
                        // appended words land at fill and fill+1: keep word 4 current
                        if (tx_fill_ff + TX_CW'(1) == nif_pkg::SRC_POS) begin
                           src_word_in = chk;
                        end
                        send_len_in = tx_fill_ff + TX_CW'(2);
                        send_pos_in = '0;
                        busy_in     = 1'b1;
                        tx_fill_in  = '0;
                        tx_sum_in   = '0;
                        tx_done_in  = 1'b1;
                     end
                  end
               end
               default: res.read_data = '0;
            endcase
         end
         nif_pkg::OP_RX_WORD: begin
            if (rx_fill_ff == nif_pkg::DEST_POS) begin
               rx_dest_in = item.rx_word;
            end
            if (rx_fill_ff < RX_CW'(nif_pkg::RX_WORDS)) begin
               rx_we      = rx_free;
               rx_fill_in = rx_fill_ff + RX_CW'(1);
            end
            rx_sum_in = nif_pkg::oc_add(rx_sum_ff, item.rx_word);
            if (item.rx_last) begin
               if (rx_dest_in == node_address || rx_dest_in == '0 || enable_ff[0]) begin
                  if (rx_free) begin
                     rx_avail_in = rx_fill_in;
                     rx_pos_in   = '0;
                     if (rx_sum_in != 16'hFFFF) begin
                        crc_error_in = 1'b1;
                     end
                     rx_done_in = 1'b1;
                     if (enable_ff[1]) begin
                        irq_in = 1'b1;
                     end
                     rx_en_in = 1'b0;
                  end else if (lost_ff != 4'hF) begin
                     lost_in = lost_ff + 4'd1;
                  end
               end
               rx_fill_in = '0;
               rx_sum_in  = '0;
               rx_dest_in = '0;
            end
         end
         nif_pkg::OP_TICK: begin
            if (tx_fill_ff == '0) begin
               tx_done_in = 1'b1;
               if (enable_ff[2]) begin
                  irq_in = 1'b1;
               end
            end
         end
         nif_pkg::OP_LINK_PULL: begin
            if (busy_ff && send_pos_ff < TX_CW'(nif_pkg::TX_WORDS)) begin
               res.tx_valid = 1'b1;
               if (send_pos_ff == send_len_ff - TX_CW'(2)) begin
                  res.tx_word = app_src_ff;
               end else if (send_pos_ff == send_len_ff - TX_CW'(1)) begin
                  res.tx_word = app_chk_ff;
               end else begin
                  res.tx_word = tx_rdata;
               end
               res.tx_last = (pos_next >= send_len_ff);
               send_pos_in = pos_next;
               if (res.tx_last) begin
                  busy_in = 1'b0;
               end
            end else begin
               busy_in = 1'b0;
            end
         end
         default: res = '0;
      endcase
      res.irq = irq_in;
   end

   assign result = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= '0;
         tx_done_ff   <= 1'b1;
         crc_error_ff <= 1'b0;
         rx_done_ff   <= 1'b0;
         lost_ff      <= '0;
         irq_ff       <= 1'b0;
         tx_fill_ff   <= '0;
         tx_sum_ff    <= '0;
         busy_ff      <= 1'b0;
         send_pos_ff  <= '0;
         send_len_ff  <= '0;
         rx_avail_ff  <= '0;
         rx_pos_ff    <= '0;
         rx_fill_ff   <= '0;
         rx_sum_ff    <= '0;
         rx_dest_ff   <= '0;
         rx_en_ff     <= 1'b1;
      end else if (advance) begin
         enable_ff    <= enable_in;
         tx_done_ff   <= tx_done_in;
         crc_error_ff <= crc_error_in;
         rx_done_ff   <= rx_done_in;
         lost_ff      <= lost_in;
         irq_ff       <= irq_in;
         tx_fill_ff   <= tx_fill_in;
         tx_sum_ff    <= tx_sum_in;
         busy_ff      <= busy_in;
         send_pos_ff  <= send_pos_in;
         send_len_ff  <= send_len_in;
         rx_avail_ff  <= rx_avail_in;
         rx_pos_ff    <= rx_pos_in;
         rx_fill_ff   <= rx_fill_in;
         rx_sum_ff    <= rx_sum_in;
         rx_dest_ff   <= rx_dest_in;
         rx_en_ff     <= rx_en_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         src_word_ff <= src_word_in;
         app_src_ff  <= app_src_in;
         app_chk_ff  <= app_chk_in;
      end
   end

   // read ahead at the position the next transfer will use
   nif_ram #(.DEPTH(nif_pkg::TX_WORDS), .WIDTH(16)) u_tx_ram (
      .clock   (clock),
      .wr_en   (advance && tx_we),
      .wr_addr (tx_fill_ff[TX_AW-1:0]),
      .wr_data (item.write_data),
      .rd_addr (advance ? send_pos_in[TX_AW-1:0] : send_pos_ff[TX_AW-1:0]),
      .rd_data (tx_rdata)
   );

   nif_ram #(.DEPTH(nif_pkg::RX_WORDS), .WIDTH(16)) u_rx_ram (
      .clock   (clock),
      .wr_en   (advance && rx_we),
      .wr_addr (rx_fill_ff[RX_AW-1:0]),
      .wr_data (item.rx_word),
      .rd_addr (advance ? rx_pos_in[RX_AW-1:0] : rx_pos_ff[RX_AW-1:0]),
      .rd_data (rx_rdata)
   );

endmodule

// ----- src/network_packet_interface_top.sv -----
// Response: the input register takes a request transfer, the response register then
// takes its result and drives rsp_valid; a stalled response holds both registers.
// Throughput: one transfer per cycle when not stalled; the input register and the
// response register each hold one transfer; store reads use a read-ahead RAM port.
// Reset: synchronous, active high; clears control state and node address,
// the transmit and receive stores keep their contents.
// ----------------------------------------------------------------------------
// network_packet_interface_top
// Packet network interface: bus registers, transmit queue and receive filter.
// ----------------------------------------------------------------------------
module network_packet_interface_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [2:0]  req_reg_offset,
   input  logic [15:0] req_write_data,
   input  logic [15:0] req_rx_word,
   input  logic        req_rx_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_read_data,
   output logic        rsp_irq,
   output logic        rsp_tx_valid,
   output logic [15:0] rsp_tx_word,
   output logic        rsp_tx_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_write_data
);

   logic                s1_valid_ff;
   nif_pkg::item_type   s1_item_ff;
   logic                rsp_valid_ff;
   nif_pkg::result_type rsp_ff;
   nif_pkg::result_type result;
   logic [15:0]         node_address_ff;
   logic                advance;
   logic                take_req;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign take_req  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_address_ff <= '0;
      end else if (csr_valid) begin
         node_address_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (take_req) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         s1_item_ff <= '{op: req_op, reg_offset: req_reg_offset, write_data: req_write_data,
                         rx_word: req_rx_word, rx_last: req_rx_last};
      end
   end

   nif_core u_core (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .item         (s1_item_ff),
      .node_address (node_address_ff),
      .result       (result)
   );

   // hold the response while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_ff.read_data;
   assign rsp_irq       = rsp_ff.irq;
   assign rsp_tx_valid  = rsp_ff.tx_valid;
   assign rsp_tx_word   = rsp_ff.tx_word;
   assign rsp_tx_last   = rsp_ff.tx_last;

endmodule

// ----- src/nif_check.sv -----
// ----------------------------------------------------------------------------
// nif_check
// Port-level checks on the packet network interface.
// ----------------------------------------------------------------------------
module nif_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_tx_word,
   input logic        rsp_tx_valid,
   input logic        rsp_tx_last
);

   // a stalled response stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // idle link word carries nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tx_valid |-> rsp_tx_word == 16'h0 && !rsp_tx_last)
      else $error("link word without valid");

   // a request transfer into an empty pipeline is followed by a response
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid && !$past(req_valid && !req_stall)
      |-> ##2 rsp_valid)
      else $error("response missing after transfer");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind network_packet_interface_top nif_check u_nif_check (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_tx_word  (rsp_tx_word),
   .rsp_tx_valid (rsp_tx_valid),
   .rsp_tx_last  (rsp_tx_last)
);
